// ----- sv/crc16_reflected_stream_assert.svh -----
// Assertion macros for the reflected CRC-16 stream block
`ifndef CRC16_REFLECTED_STREAM_ASSERT_SVH
`define CRC16_REFLECTED_STREAM_ASSERT_SVH

// checked on every rising clock edge, ignored while reset is high
`define CRCRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every rising clock edge, reset included
`define CRCRS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ----- sv/crcrs_pkg.sv -----
// Shared types and constants for the reflected CRC-16 stream block
package crcrs_pkg;

   localparam int CrcWidth  = 16;
   localparam int ByteWidth = 8;

   localparam logic [CrcWidth-1:0] START_RESET = 16'h1121;
   localparam logic [CrcWidth-1:0] POLY_RESET  = 16'h8408;
   localparam logic [CrcWidth-1:0] FINAL_XOR   = 16'hFFFF;

   typedef enum logic [0:0] {
      CSR_START_VALUE = 1'b0,
      CSR_POLYNOMIAL  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CrcWidth-1:0] start_value;
      logic [CrcWidth-1:0] polynomial;
   } cfg_type;

endpackage

// ----- sv/crc16_reflected_stream.sv -----
// Top level: byte-serial reflected CRC-16 with input and result registers
//
// Input channel req_*: one item per handshake, carrying req_data_byte,
// req_has_byte (byte present) and req_last_byte (end of message). An item
// with neither flag set changes nothing; an item with only the last flag
// closes an empty or already fed message.
// Result channel rsp_*: one item per message, rsp_crc_value = remainder
// XOR 0xFFFF, issued for every input item that has the last flag.
// A last item moves from the input register to the result register once
// that is free. Throughput: one input item per cycle, unless a last item
// waits on an unread result; the eight-step byte fold from the input to
// the remainder register is combinational. The result register holds a
// finished CRC while the next message streams in; only its last item waits.
// Receiver stall: rsp_valid and rsp_crc_value hold; req_stall rises only
// when a last item sits in the input register behind an unread result.
// Reset (synchronous): empties both registers, restores start value 0x1121
// and polynomial 0x8408, and loads the remainder with the start value.
// csr_*: write enable, index (0 start value, 1 polynomial) and data; write
// only while the block is idle. A new start value applies at the next reload.
module crc16_reflected_stream (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [crcrs_pkg::ByteWidth-1:0]   req_data_byte,
   input  logic                              req_has_byte,
   input  logic                              req_last_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [crcrs_pkg::CrcWidth-1:0]    rsp_crc_value,
   input  logic                              csr_write_enable,
   input  crcrs_pkg::csr_index_type          csr_index,
   input  logic [crcrs_pkg::CrcWidth-1:0]    csr_write_data
);
   import crcrs_pkg::*;

   `include "crc16_reflected_stream_assert.svh"

   cfg_type cfg;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_has_ff;
   logic                  in_last_ff;
   logic [CrcWidth-1:0]   remainder_ff;
   logic [CrcWidth-1:0]   remainder_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CrcWidth-1:0]   rsp_crc_ff;
   logic [CrcWidth-1:0]   folded;
   logic [CrcWidth-1:0]   updated;
   logic                  out_free;
   logic                  advance;
   logic                  load_in;

   crcrs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   crcrs_fold u_fold (
      .remainder  (remainder_ff),
      .data_byte  (in_byte_ff),
      .polynomial (cfg.polynomial),
      .folded     (folded)
   );

   assign updated  = in_has_ff ? folded : remainder_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign advance  = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign load_in  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      remainder_in = remainder_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in = 1'b0;
         if (in_last_ff) begin
            remainder_in = cfg.start_value;
            rsp_valid_in = 1'b1;
         end else begin
            remainder_in = updated;
         end
      end
      if (load_in) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         remainder_ff <= START_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         remainder_ff <= remainder_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         in_byte_ff <= req_data_byte;
         in_has_ff  <= req_has_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_crc_ff <= updated ^ FINAL_XOR;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   `CRCRS_ASSERT(a_rsp_from_last,
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff),
      "result raised without a last item")
   `CRCRS_ASSERT(a_reload_after_last,
      (advance && in_last_ff) |=> (remainder_ff == $past(cfg.start_value)),
      "remainder not reloaded after message end")
   `CRCRS_ASSERT(a_hold_when_blocked,
      (in_valid_ff && !advance) |=>
         (in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff)),
      "blocked input item lost or changed")
   `CRCRS_ASSERT_ALWAYS(a_reset_empties,
      reset |=> (!in_valid_ff && !rsp_valid_ff),
      "pipeline not empty after reset")

endmodule

// ----- sv/crcrs_csr.sv -----
// Configuration registers: start value and reflected polynomial
module crcrs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  crcrs_pkg::csr_index_type          csr_index,
   input  logic [crcrs_pkg::CrcWidth-1:0]    csr_write_data,
   output crcrs_pkg::cfg_type                cfg
);
   import crcrs_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_VALUE: cfg_in.start_value = csr_write_data;
            CSR_POLYNOMIAL:  cfg_in.polynomial  = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_value <= START_RESET;
         cfg_ff.polynomial  <= POLY_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- sv/crcrs_fold.sv -----
// Combinational fold of one byte into the remainder, eight bit steps LSB first
module crcrs_fold (
   input  logic [crcrs_pkg::CrcWidth-1:0]  remainder,
   input  logic [crcrs_pkg::ByteWidth-1:0] data_byte,
   input  logic [crcrs_pkg::CrcWidth-1:0]  polynomial,
   output logic [crcrs_pkg::CrcWidth-1:0]  folded
);
   import crcrs_pkg::*;

   always_comb begin
      logic [CrcWidth-1:0] rem;
      rem = remainder ^ {{(CrcWidth-ByteWidth){1'b0}}, data_byte};
      for (int k = 0; k < ByteWidth; k++) begin
         if (rem[0]) begin
            rem = (rem >> 1) ^ polynomial;
         end else begin
            rem = rem >> 1;
         end
      end
      folded = rem;
   end

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the reflected CRC-16 byte stream block
`timescale 1ns / 100ps

module tb;
   import crcrs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 500;
   localparam int PHASES = 8;
   localparam logic [CrcWidth-1:0] EMPTY_AT_RESET = 16'hEEDE;
   localparam logic [CrcWidth-1:0] X25_CHECK = 16'h906E;

   typedef struct {
      logic [ByteWidth-1:0] data;
      logic has;
      logic last;
      bit pinned;
      logic [CrcWidth-1:0] crc;
   } crc_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [ByteWidth-1:0] req_data_byte = '0;
   logic req_has_byte = 1'b0;
   logic req_last_byte = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [CrcWidth-1:0] rsp_crc_value;
   logic csr_write_enable = 1'b0;
   csr_index_type csr_index = CSR_START_VALUE;
   logic [CrcWidth-1:0] csr_write_data = '0;

   logic [CrcWidth-1:0] cfg_start = START_RESET;
   logic [CrcWidth-1:0] cfg_poly = POLY_RESET;
   logic [CrcWidth-1:0] crc_running = START_RESET;
   logic [CrcWidth-1:0] crc_expected[$];
   logic [CrcWidth-1:0] crc_want;
   int mismatches = 0;
   int cycle_count = 0;
   int items_sent = 0;
   int gap_max = 3;
   int burst_left = 0;
   bit hold_off_request = 1'b0;

   crc16_reflected_stream u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_has_byte     (req_has_byte),
      .req_last_byte    (req_last_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_crc_value    (rsp_crc_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** crc16_reflected_stream: FAILED **");
         $finish;
      end
   end

   // LSB-first fold of one byte into the remainder
   function automatic logic [CrcWidth-1:0] fold_crc_byte(input logic [CrcWidth-1:0] rem,
                                                         input logic [ByteWidth-1:0] b,
                                                         input logic [CrcWidth-1:0] poly);
      logic [CrcWidth-1:0] r;
      r = rem ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ poly) : (r >> 1);
      end
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (crc_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected crc result: got %h", rsp_crc_value);
         end else begin
            crc_want = crc_expected.pop_front();
            if (rsp_crc_value !== crc_want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("crc mismatch: expected %h, got %h", crc_want, rsp_crc_value);
            end
         end
      end
   end

   // receiver stall patterns, plus a long hold-off on request
   initial begin : receiver
      int mode;
      int mode_left;
      mode = 0;
      mode_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
               0: begin
                  rsp_stall <= 1'b0;
               end
               1: begin
                  rsp_stall <= ($urandom_range(0, 3) == 0);
               end
               2: begin
                  rsp_stall <= 1'($urandom_range(0, 1));
               end
               default: begin
                  rsp_stall <= ((mode_left % 4) != 0);
               end
            endcase
         end
      end
   end

   task automatic offer_item(input logic [ByteWidth-1:0] b, input logic has, input logic last,
                             input bit pinned = 1'b0, input logic [CrcWidth-1:0] pinned_crc = '0);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (gap_max > 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_has_byte <= has;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (has || last)
         items_sent++;
      if (has)
         crc_running = fold_crc_byte(crc_running, b, cfg_poly);
      if (last) begin
         crc_expected.push_back(pinned ? pinned_crc : (crc_running ^ FINAL_XOR));
         crc_running = cfg_start;
      end
   endtask

   // lower valid, wait out every pending result and the output register
   task automatic settle();
      req_valid <= 1'b0;
      while (crc_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [CrcWidth-1:0] start_v,
                             input logic [CrcWidth-1:0] poly_v);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_START_VALUE;
      csr_write_data <= start_v;
      @(posedge clock);
      csr_index <= CSR_POLYNOMIAL;
      csr_write_data <= poly_v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_start = start_v;
      cfg_poly = poly_v;
   endtask

   function automatic logic [ByteWidth-1:0] pick_byte();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom);
   endfunction

   task automatic random_message();
      int len;
      bit empty_end;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      empty_end = (len == 0) || ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0)
            offer_item(8'($urandom), 1'b0, 1'b0);
         offer_item(pick_byte(), 1'b1, !empty_end && (i == len - 1));
      end
      if (empty_end)
         offer_item(8'($urandom), 1'b0, 1'b1);
   endtask

   crc_row_type directed_rows[16] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_AT_RESET},
      '{8'h5A, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_AT_RESET},
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_AT_RESET},
      '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{8'h01, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h80, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hC9, 1'b0, 1'b0, 1'b0, 16'h0000},
      '{8'hAA, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h55, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
      '{8'h33, 1'b0, 1'b1, 1'b0, 16'h0000},
      '{8'h7E, 1'b1, 1'b1, 1'b0, 16'h0000},
      '{8'hC3, 1'b1, 1'b0, 1'b0, 16'h0000}
   };

   initial begin : stimulus
      string check_text;
      logic [CrcWidth-1:0] phase_start;
      logic [CrcWidth-1:0] phase_poly;
      int phase_goal;
      check_text = "123456789";
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         offer_item(directed_rows[i].data, directed_rows[i].has, directed_rows[i].last,
                    directed_rows[i].pinned, directed_rows[i].crc);
      settle();

      // message left open above: new start value applies at the next reload, not to the open message
      set_config(16'hFFFF, POLY_RESET);
      offer_item(8'hA5, 1'b1, 1'b1);
      for (int i = 0; i < check_text.len(); i++)
         offer_item(check_text[i], 1'b1, i == check_text.len() - 1, 1'b1, X25_CHECK);
      settle();

      items_sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin phase_start = START_RESET; phase_poly = POLY_RESET; end
            1: begin phase_start = 16'h0000; phase_poly = 16'h0000; end
            2: begin phase_start = 16'hFFFF; phase_poly = 16'hFFFF; end
            3: begin phase_start = 16'h0000; phase_poly = 16'hFFFF; end
            4: begin phase_start = 16'hFFFF; phase_poly = 16'h0000; end
            default: begin phase_start = 16'($urandom); phase_poly = 16'($urandom); end
         endcase
         set_config(phase_start, phase_poly);
         gap_max = ((phase % 3) == 0) ? 0 : int'($urandom_range(2, 8));
         burst_left = 0;
         phase_goal = items_sent + RANDOM_ITEMS / PHASES;

         if (phase == 2) begin
            hold_off_request = 1'b1;
            for (int i = 0; i < 40; i++)
               offer_item(pick_byte(), 1'b1, 1'b1);
         end

         while (items_sent < phase_goal)
            random_message();

         // sometimes leave a message open across the register write
         if ($urandom_range(0, 1)) begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
               offer_item(pick_byte(), 1'b1, 1'b0);
         end
         settle();
      end

      mismatches += crc_expected.size();
      if (mismatches == 0)
         $display("** crc16_reflected_stream: PASSED **");
      else
         $display("** crc16_reflected_stream: FAILED **");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/crcrs_pkg.sv
sv/crcrs_csr.sv
sv/crcrs_fold.sv
sv/crc16_reflected_stream.sv
tb/sv/tb.sv
